// ----- hw/rtl/ctd_pkg.sv -----
// Shared widths, constants and pipeline word type for the degree-input series cosine.
package ctd_pkg;

  localparam int NUM_TERMS = 4;
  localparam int MAX_TERMS = 8;
  localparam int NT        = (NUM_TERMS > MAX_TERMS) ? MAX_TERMS :
                             ((NUM_TERMS < 0) ? 0 : NUM_TERMS);

  localparam int ANG_W = 18;
  localparam int MAG_W = 18;
  localparam int D2R_W = 27;
  localparam int X_W   = 24;
  localparam int X2_W  = 27;
  localparam int T_W   = 32;
  localparam int R_W   = 32;
  localparam int S_W   = 36;
  localparam int OUT_W = 24;

  // pi/180 scaled by 2^32
  localparam logic [D2R_W-1:0] DEG2RAD = 27'd74961321;
  localparam logic [T_W-1:0]   Q20_ONE = 32'd1048576;

  // 1/((2k-1)*2k) scaled by 2^32
  localparam logic [R_W-1:0] RECIP_TAB [MAX_TERMS] = '{
    32'd2147483648, 32'd357913941, 32'd143165577, 32'd76695845,
    32'd47721859,   32'd32537631,  32'd23598721,  32'd17895697
  };

  // last series term is subtracted when the term count is odd
  localparam logic LAST_NEG = ((NT % 2) == 1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -24'sh800000;

  typedef struct packed {
    logic                  vld;
    logic [X2_W-1:0]       x2;
    logic [T_W-1:0]        t;
    logic signed [S_W-1:0] s;
  } ctd_pipe_t;

endpackage

// ----- hw/rtl/ctd_front.sv -----
// Front stages: magnitude, conversion to radians and squaring.
module ctd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic signed [ctd_pkg::ANG_W-1:0] angle,
  output ctd_pkg::ctd_pipe_t               pipe_o
);
  import ctd_pkg::*;

  logic             v0_r, v1_r, v2_r;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [X_W-1:0]   x_r, x_nxt;
  logic [X2_W-1:0]  x2_r, x2_nxt;
  logic [MAG_W+D2R_W-1:0] xp;
  logic [2*X_W-1:0]       sq;

  // take the magnitude; the most negative code maps onto 2^17
  assign mag_nxt = angle[ANG_W-1] ? (~angle + 1'b1) : angle;

  assign xp    = MAG_W'(mag_r) * DEG2RAD + (MAG_W+D2R_W)'(1 << 19);
  assign x_nxt = xp[20 +: X_W];

  assign sq     = x_r * x_r + (2*X_W)'(1 << 19);
  assign x2_nxt = sq[20 +: X2_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    x_r   <= x_nxt;
    x2_r  <= x2_nxt;
  end

  assign pipe_o.vld = v2_r;
  assign pipe_o.x2  = x2_r;
  assign pipe_o.t   = Q20_ONE;
  assign pipe_o.s   = '0;

endmodule

// ----- hw/rtl/ctd_term.sv -----
// One series term: reciprocal scale, multiply by x squared, fold previous term into the sum.
module ctd_term (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ctd_pkg::ctd_pipe_t           pipe_i,
  input  logic [ctd_pkg::R_W-1:0]      recip,
  input  logic                         add_neg,
  output ctd_pkg::ctd_pipe_t           pipe_o
);
  import ctd_pkg::*;

  logic                  v1_r, v2_r;
  logic [T_W-1:0]        tm_r, tm_nxt, t_r, t_nxt;
  logic [X2_W-1:0]       x2a_r, x2b_r;
  logic signed [S_W-1:0] sa_r, sa_nxt, sb_r;
  logic [T_W+R_W-1:0]    rp;
  logic [T_W+X2_W:0]     xp;
  logic signed [S_W-1:0] t_ext;

  // stage one: scale by 1/((2k-1)2k) and accumulate the previous term
  assign rp     = T_W'(pipe_i.t) * recip + (T_W+R_W)'(64'd1 << 31);
  assign tm_nxt = rp[32 +: T_W];
  assign t_ext  = S_W'(pipe_i.t);
  assign sa_nxt = add_neg ? (pipe_i.s - t_ext) : (pipe_i.s + t_ext);

  // stage two: multiply by x squared
  assign xp    = (T_W+X2_W+1)'(tm_r) * x2a_r + (T_W+X2_W+1)'(1 << 19);
  assign t_nxt = xp[20 +: T_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= pipe_i.vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    tm_r  <= tm_nxt;
    x2a_r <= pipe_i.x2;
    sa_r  <= sa_nxt;
    t_r   <= t_nxt;
    x2b_r <= x2a_r;
    sb_r  <= sa_r;
  end

  assign pipe_o.vld = v2_r;
  assign pipe_o.x2  = x2b_r;
  assign pipe_o.t   = t_r;
  assign pipe_o.s   = sb_r;

endmodule

// ----- hw/rtl/ctd_out.sv -----
// Output stages: fold in the last term, round to 16 fraction bits and saturate.
module ctd_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ctd_pkg::ctd_pipe_t               pipe_i,
  input  logic                             last_neg,
  output logic                             out_vld,
  output logic signed [ctd_pkg::OUT_W-1:0] out_val
);
  import ctd_pkg::*;

  logic                    v1_r, v2_r;
  logic signed [S_W-1:0]   sf_r, sf_nxt, t_ext, rnd;
  logic signed [S_W-5:0]   q;
  logic signed [OUT_W-1:0] cos_r, cos_nxt;

  assign t_ext  = S_W'(pipe_i.t);
  assign sf_nxt = last_neg ? (pipe_i.s - t_ext) : (pipe_i.s + t_ext);

  // floor((s + 8) / 16), then clamp to the field range
  assign rnd = sf_r + S_W'(8);
  assign q   = rnd[S_W-1:4];

  always_comb begin
    priority if (q > (S_W-4)'(OUT_MAX)) begin
      cos_nxt = OUT_MAX;
    end else if (q < (S_W-4)'(OUT_MIN)) begin
      cos_nxt = OUT_MIN;
    end else begin
      cos_nxt = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= pipe_i.vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sf_r  <= sf_nxt;
    cos_r <= cos_nxt;
  end

  assign out_vld = v2_r;
  assign out_val = cos_r;

endmodule

// ----- hw/rtl/cosine_taylor_degrees_top.sv -----
// Top level of the pipelined degree-input Maclaurin cosine.
//
//  channel | ports                    | handshake
//  --------+--------------------------+-------------------------------------
//  input   | start, busy, in_angle_deg| word taken when start high, busy low
//  result  | out_valid, out_cos_value | one-cycle strobe, always taken
//
// One word enters every cycle; busy is held low since nothing downstream
// can stall. The pipeline has NT series terms (four by default): three
// front stages, two per term (one multiplier each), two at the output
// for the final sum, rounding and saturation.
// Reset (rst_n low, synchronous) drops every valid bit; payload is not reset.
// The result side has no back-pressure, so no stage ever holds.
module cosine_taylor_degrees_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [ctd_pkg::ANG_W-1:0] in_angle_deg,
  output logic                             out_valid,
  output logic signed [ctd_pkg::OUT_W-1:0] out_cos_value
);
  import ctd_pkg::*;

  // pipeline words between the stage groups; chain[0] leaves the front end
  ctd_pipe_t chain [NT+1];
  logic      in_vld;

  // every stage advances each cycle, so a new word is always welcome
  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  ctd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_vld),
    .angle  (in_angle_deg),
    .pipe_o (chain[0])
  );

  // one unit per term; each folds the previous term into the sum with
  // alternating sign, the constant one entering as a positive term
  for (genvar k = 0; k < NT; k++) begin : g_term
    ctd_term u_term (
      .clk     (clk),
      .rst_n   (rst_n),
      .pipe_i  (chain[k]),
      .recip   (RECIP_TAB[k]),
      .add_neg (1'((k % 2) == 1)),
      .pipe_o  (chain[k+1])
    );
  end

  ctd_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .pipe_i   (chain[NT]),
    .last_neg (LAST_NEG),
    .out_vld  (out_valid),
    .out_val  (out_cos_value)
  );

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for the degree-input Maclaurin cosine: directed table, then random angles.
module testbench;

  localparam int ANG_W = ctd_pkg::ANG_W;
  localparam int OUT_W = ctd_pkg::OUT_W;

  // Pipeline depth as given at the head of the top level: three front stages,
  // two per series term, two at the output.
  localparam int LATENCY        = 3 + 2 * ctd_pkg::NT + 2;
  localparam int RANDOM_WORDS   = 1250;
  // The limit covers the longest sender gap from pick_gap plus LATENCY.
  localparam int WATCHDOG_LIMIT = 2000;

  // Result limits of the 24-bit signed output.
  localparam longint COS_CEIL  = 64'sd8388607;
  localparam longint COS_FLOOR = -64'sd8388608;

  // Reciprocals of (2k-1)*2k scaled by 2^32, one per series term.
  localparam longint unsigned INV_FACT_STEP [8] = '{
    64'd2147483648, 64'd357913941, 64'd143165577, 64'd76695845,
    64'd47721859,   64'd32537631,  64'd23598721,  64'd17895697
  };

  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic                    typed;    // expected value below is exact, not predicted
    logic signed [OUT_W-1:0] cos_val;
  } angle_row_t;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic signed [OUT_W-1:0] cos_val;
  } cos_expect_t;

  // Directed words. Angle zero gives exactly 1.0 (65536 in Q16). At the 18-bit
  // extremes (about 512 degrees) the four-term series is far above 128, so the
  // output pins at its ceiling. The rest are left to the predictor.
  localparam int N_DIRECTED = 22;
  localparam angle_row_t DIRECTED [N_DIRECTED] = '{
    '{18'sd0,       1'b1, 24'sd65536},
    '{18'sd131071,  1'b1, 24'sd8388607},   // largest positive code
    '{-18'sd131072, 1'b1, 24'sd8388607},   // most negative code
    '{18'sd1,       1'b0, 24'sd0},
    '{-18'sd1,      1'b0, 24'sd0},
    '{18'sd128,     1'b0, 24'sd0},
    '{18'sd256,     1'b0, 24'sd0},
    '{-18'sd256,    1'b0, 24'sd0},
    '{18'sd11520,   1'b0, 24'sd0},         // 45 degrees
    '{18'sd15360,   1'b0, 24'sd0},         // 60 degrees
    '{18'sd23040,   1'b0, 24'sd0},         // 90 degrees
    '{-18'sd23040,  1'b0, 24'sd0},
    '{18'sd46080,   1'b0, 24'sd0},         // 180 degrees
    '{-18'sd46080,  1'b0, 24'sd0},
    '{18'sd69120,   1'b0, 24'sd0},         // 270 degrees
    '{18'sd92160,   1'b0, 24'sd0},         // a full turn, top of intended range
    '{-18'sd92160,  1'b0, 24'sd0},
    '{18'sd92161,   1'b0, 24'sd0},         // just past a full turn, not limited
    '{-18'sd92161,  1'b0, 24'sd0},
    '{18'sd87381,   1'b0, 24'sd0},         // alternating bit patterns
    '{-18'sd87382,  1'b0, 24'sd0},
    '{18'sd43690,   1'b0, 24'sd0}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [ANG_W-1:0] in_angle_deg;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_cos_value;

  cos_expect_t pending_cos [$];
  int          err_count   = 0;
  int          idle_cycles = 0;

  cosine_taylor_degrees_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_cos_value(out_cos_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Series cosine in fixed point: degrees to Q20 radians, square, then each
  // term built from the previous by one reciprocal and one x^2 multiply, all
  // rounded half up; finally Q20 to Q16 with rounding and saturation.
  function automatic logic signed [OUT_W-1:0] series_cosine(input logic [ANG_W-1:0] raw);
    longint unsigned mag;
    longint unsigned rad;
    longint unsigned rad_sq;
    longint unsigned term;
    longint          sum;
    longint          q16;
    int              n_terms;
    mag     = raw[ANG_W-1] ? ((64'd1 << ANG_W) - 64'(raw)) : 64'(raw);
    rad     = (mag * 64'd74961321 + (64'd1 << 19)) >> 20;
    rad_sq  = (rad * rad + (64'd1 << 19)) >> 20;
    term    = 64'd1 << 20;
    sum     = 64'sd1 << 20;
    n_terms = (ctd_pkg::NUM_TERMS > 8) ? 8 :
              ((ctd_pkg::NUM_TERMS < 0) ? 0 : ctd_pkg::NUM_TERMS);
    for (int k = 0; k < n_terms; k++) begin
      term = (term * INV_FACT_STEP[k] + (64'd1 << 31)) >> 32;
      term = (term * rad_sq + (64'd1 << 19)) >> 20;
      // signs alternate, starting with minus x^2/2!
      if (k % 2 == 1) sum = sum + longint'(term);
      else            sum = sum - longint'(term);
    end
    q16 = (sum + 64'sd8) >>> 4;
    if (q16 > COS_CEIL)  q16 = COS_CEIL;
    if (q16 < COS_FLOOR) q16 = COS_FLOOR;
    return q16[OUT_W-1:0];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Most angles inside a full turn, some near zero, some across the whole
  // 18-bit code space, and a sprinkling of the extremes.
  function automatic logic signed [ANG_W-1:0] pick_angle();
    int r;
    int a;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      a = int'($urandom_range(0, 184320)) - 92160;
    end else if (r < 78) begin
      a = int'($urandom_range(0, 4096)) - 2048;
    end else if (r < 95) begin
      a = int'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0:       a = 131071;
        1:       a = -131072;
        2:       a = 92160;
        3:       a = -92160;
        default: a = 0;
      endcase
    end
    return a[ANG_W-1:0];
  endfunction

  // Present one word and hold it until the block takes it, then file the
  // expected result. Start is only written once per time step.
  task automatic send_angle(input logic signed [ANG_W-1:0] angle,
                            input logic                    typed,
                            input logic signed [OUT_W-1:0] typed_val,
                            input bit                      steady);
    int          gap;
    cos_expect_t want;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_angle_deg <= angle;
    // advance until an edge sees start high with busy low
    do @(posedge clk); while (busy !== 1'b0);
    want.angle   = angle;
    want.cos_val = typed ? typed_val : series_cosine(angle);
    pending_cos.push_back(want);
  endtask

  initial begin : stimulus
    bit steady;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_angle_deg <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table with random gaps.
    foreach (DIRECTED[i]) begin
      send_angle(DIRECTED[i].angle, DIRECTED[i].typed, DIRECTED[i].cos_val, 1'b0);
    end

    // Random angles; every fifty words decide whether to run back to back.
    steady = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      send_angle(pick_angle(), 1'b0, '0, steady);
    end
    start <= 1'b0;

    // Drain: wait for every expected word, then a little longer to catch strays.
    while (pending_cos.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Result checker: every strobe must match the oldest outstanding angle.
  always @(posedge clk) begin
    cos_expect_t head;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_cos.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got cos %0d",
                 $time, out_cos_value);
        err_count <= err_count + 1;
      end else begin
        head = pending_cos.pop_front();
        if (out_cos_value !== head.cos_val) begin
          $display("%0t: angle %0d cos mismatch, expected %0d, got %0d",
                   $time, head.angle, head.cos_val, out_cos_value);
          err_count <= err_count + 1;
        end
      end
    end
  end

  // Watchdog: drop the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/ctd_pkg.sv
hw/rtl/ctd_front.sv
hw/rtl/ctd_term.sv
hw/rtl/ctd_out.sv
hw/rtl/cosine_taylor_degrees_top.sv
dv/testbench.sv
